// ===== rtl/pfp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the particulate frame parser: types, constants and codes.
// Used by pfp_front, pfp_queue, pfp_back and particulate_frame_parser.
package pfp_pkg;

	// Frame format
	localparam logic [7:0] PRE_A = 8'h42;
	localparam logic [7:0] PRE_B = 8'h4D;
	localparam logic [4:0] POS_LAST = 5'd31;
	localparam logic [4:0] POS_SUM_END = 5'd30;
	localparam logic [4:0] POS_RD_FIRST = 5'd4;
	localparam int NUM_RD = 6;
	localparam int NUM_RD_BYTES = 2 * NUM_RD;

	// Operation codes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_POLL = 2'd1;
	localparam logic [1:0] OP_RESYNC = 2'd2;

	// Frame outcome codes
	localparam logic [1:0] OUT_NONE = 2'd0;
	localparam logic [1:0] OUT_GOOD = 2'd1;
	localparam logic [1:0] OUT_BAD = 2'd2;

	// Register map
	localparam int PADDR_W = 3;
	localparam logic REG_WARMUP = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;
	localparam int WARMUP_W = 20;
	localparam int TIMEOUT_W = 22;
	localparam logic [WARMUP_W-1:0] WARMUP_RST = 20'd30000;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 22'd10000;

	typedef logic [NUM_RD-1:0][15:0] readings_t;

	// One classified request from front to back
	typedef struct packed {
		logic [1:0] outcome;
		logic resync;
		logic [31:0] diff_start;
		logic [31:0] diff_ref;
		readings_t readings;
	} entry_t;

	// One finished result
	typedef struct packed {
		logic new_reading;
		logic checksum_error;
		logic reading_valid;
		logic warmed_up;
		logic timed_out;
		readings_t readings;
	} result_t;

endpackage

// ===== rtl/particulate_frame_parser.sv =====
`timescale 1ns / 1ps
// Top level of the particulate sensor frame parser.
// Depends on pfp_pkg, pfp_front, pfp_queue and pfp_back.
//
// Usage:
//   Input channel (in_valid/in_ready): operation, rx_byte, now_ms. Each
//   request is a received byte, a time poll or a resync.
//   Output channel (out_valid/out_ready): exactly one result per request:
//   frame flags, warm-up and timeout flags and the six held readings.
//   Config port (APB): warmup_ms at address 0, timeout_ms at address 4,
//   written on psel & penable & pwrite, readable; pready is tied high.
// Path: a result passes through a queue slot and then the output register
//   after its request is accepted. Throughput: one request per cycle while the queue has room.
// The front end takes a request whenever the two-entry queue has room, so
//   it keeps accepting while a finished result waits in the output
//   register; when the receiver stalls the queue fills and in_ready drops.
// Reset: hunt for preamble, no held reading, limits at 30000 and 10000 ms;
//   the start time is taken from the first request after reset.
module particulate_frame_parser import pfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] operation,
	input logic [7:0] rx_byte,
	input logic [31:0] now_ms,
	output logic out_valid,
	input logic out_ready,
	output logic new_reading,
	output logic checksum_error,
	output logic reading_valid,
	output logic warmed_up,
	output logic timed_out,
	output logic [15:0] pm1_0_std,
	output logic [15:0] pm2_5_std,
	output logic [15:0] pm10_std,
	output logic [15:0] pm1_0_amb,
	output logic [15:0] pm2_5_amb,
	output logic [15:0] pm10_amb,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [WARMUP_W-1:0] warmup_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic q_push, q_full, q_pop, q_not_empty;
	entry_t push_entry, pop_entry;
	result_t res;

	// configuration registers
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {10'd0, timeout_q} : {12'd0, warmup_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= WARMUP_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_WARMUP) begin
				warmup_q <= pwdata[WARMUP_W-1:0];
			end else begin
				timeout_q <= pwdata[TIMEOUT_W-1:0];
			end
		end
	end

	pfp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.rx_byte(rx_byte),
		.now_ms(now_ms),
		.q_full(q_full),
		.q_push(q_push),
		.q_entry(push_entry)
	);

	pfp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(push_entry),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.pop_data(pop_entry)
	);

	pfp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_entry(pop_entry),
		.q_pop(q_pop),
		.warmup_ms(warmup_q),
		.timeout_ms(timeout_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result(res)
	);

	// result fields
	assign new_reading = res.new_reading;
	assign checksum_error = res.checksum_error;
	assign reading_valid = res.reading_valid;
	assign warmed_up = res.warmed_up;
	assign timed_out = res.timed_out;
	assign pm1_0_std = res.readings[0];
	assign pm2_5_std = res.readings[1];
	assign pm10_std = res.readings[2];
	assign pm1_0_amb = res.readings[3];
	assign pm2_5_amb = res.readings[4];
	assign pm10_amb = res.readings[5];

endmodule

// ===== rtl/pfp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, tracks frame position and checksum, keeps the
// time references and classifies each request. Depends on pfp_pkg.
module pfp_front import pfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] operation,
	input logic [7:0] rx_byte,
	input logic [31:0] now_ms,
	input logic q_full,
	output logic q_push,
	output entry_t q_entry
);

	logic [4:0] pos_q;
	logic [15:0] sum_q;
	logic started_q;
	logic [31:0] start_time_q;
	logic [31:0] last_good_q;
	logic have_good_q;
	logic [7:0] store_q [NUM_RD_BYTES];
	logic [7:0] byte30_q;

	logic is_byte, is_resync, at_last, good, bad, have_good_nx;
	logic [31:0] start_eff, ref_eff;
	logic [15:0] sum_add;
	readings_t rd_w;

	assign in_ready = !q_full;
	assign q_push = in_valid && in_ready;

	assign is_byte = (operation == OP_BYTE);
	assign is_resync = (operation == OP_RESYNC);
	assign at_last = is_byte && (pos_q == POS_LAST);
	assign good = at_last && (sum_q == {byte30_q, rx_byte});
	assign bad = at_last && !good;
	assign sum_add = sum_q + {8'd0, rx_byte};

	// readings, big-endian pairs from bytes 4..15
	always_comb begin
		for (int i = 0; i < NUM_RD; i++) begin
			rd_w[i] = {store_q[2*i], store_q[2*i+1]};
		end
	end

	// time differences after this request's state update
	assign start_eff = started_q ? start_time_q : now_ms;
	assign have_good_nx = is_resync ? 1'b0 : (good ? 1'b1 : have_good_q);
	always_comb begin
		if (good) begin
			ref_eff = now_ms;
		end else if (have_good_nx) begin
			ref_eff = last_good_q;
		end else begin
			ref_eff = start_eff;
		end
	end

	always_comb begin
		q_entry.outcome = good ? OUT_GOOD : (bad ? OUT_BAD : OUT_NONE);
		q_entry.resync = is_resync;
		q_entry.diff_start = now_ms - start_eff;
		q_entry.diff_ref = now_ms - ref_eff;
		q_entry.readings = rd_w;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			started_q <= 1'b0;
			start_time_q <= '0;
			last_good_q <= '0;
			have_good_q <= 1'b0;
		end else if (q_push) begin
			started_q <= 1'b1;
			start_time_q <= start_eff;
			have_good_q <= have_good_nx;
			if (good) begin
				last_good_q <= now_ms;
			end
			if (is_resync) begin
				pos_q <= '0;
			end else if (is_byte) begin
				case (pos_q)
					5'd0: begin
						if (rx_byte == PRE_A) begin
							sum_q <= {8'd0, rx_byte};
							pos_q <= 5'd1;
						end
					end
					5'd1: begin
						if (rx_byte == PRE_B) begin
							sum_q <= sum_add;
							pos_q <= 5'd2;
						end else if (rx_byte == PRE_A) begin
							sum_q <= {8'd0, rx_byte};
						end else begin
							pos_q <= '0;
						end
					end
					default: begin
						if (pos_q < POS_SUM_END) begin
							sum_q <= sum_add;
						end
						pos_q <= (pos_q == POS_LAST) ? 5'd0 : pos_q + 5'd1;
					end
				endcase
			end
		end
	end

	// frame bytes that are read later
	always_ff @(posedge clk) begin
		if (q_push && is_byte) begin
			for (int i = 0; i < NUM_RD_BYTES; i++) begin
				if (pos_q == POS_RD_FIRST + 5'(i)) begin
					store_q[i] <= rx_byte;
				end
			end
			if (pos_q == POS_SUM_END) begin
				byte30_q <= rx_byte;
			end
		end
	end

endmodule

// ===== rtl/pfp_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between front and back end.
// Depends on pfp_pkg for the entry type.
module pfp_queue import pfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_data,
	output logic full,
	input logic pop,
	output logic not_empty,
	output entry_t pop_data
);

	entry_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/pfp_back.sv =====
`timescale 1ns / 1ps
// Back end: compares time differences against the limits, holds the latest
// readings and valid mark, drives the output register. Depends on pfp_pkg.
module pfp_back import pfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_not_empty,
	input entry_t q_entry,
	output logic q_pop,
	input logic [WARMUP_W-1:0] warmup_ms,
	input logic [TIMEOUT_W-1:0] timeout_ms,
	output logic out_valid,
	input logic out_ready,
	output result_t result
);

	logic out_valid_q;
	result_t res_q;
	readings_t readings_q;
	logic latest_valid_q;

	logic warm, late, is_good, lv_nx;
	readings_t rd_nx;

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result = res_q;

	// flags and held reading after this request
	assign warm = q_entry.diff_start >= {12'd0, warmup_ms};
	assign late = q_entry.diff_ref > {10'd0, timeout_ms};
	assign is_good = (q_entry.outcome == OUT_GOOD);
	assign lv_nx = q_entry.resync ? 1'b0 : (is_good ? warm : latest_valid_q);
	assign rd_nx = is_good ? q_entry.readings : readings_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			latest_valid_q <= 1'b0;
			readings_q <= '0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
			latest_valid_q <= lv_nx;
			readings_q <= rd_nx;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.new_reading <= is_good && warm;
			res_q.checksum_error <= (q_entry.outcome == OUT_BAD);
			res_q.reading_valid <= lv_nx;
			res_q.warmed_up <= warm;
			res_q.timed_out <= late;
			res_q.readings <= rd_nx;
		end
	end

endmodule

// ===== tb/pfp_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the particulate frame parser: mirrors frame hunting,
// checksum, reading latch and warm-up/timeout tracking, compares each result.
// Depends on pfp_pkg; instantiated by particulate_frame_parser_tb.
module pfp_result_checker import pfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] operation,
	input logic [7:0] rx_byte,
	input logic [31:0] now_ms,
	input logic out_valid,
	input logic out_ready,
	input logic new_reading,
	input logic checksum_error,
	input logic reading_valid,
	input logic warmed_up,
	input logic timed_out,
	input logic [15:0] pm1_0_std,
	input logic [15:0] pm2_5_std,
	input logic [15:0] pm10_std,
	input logic [15:0] pm1_0_amb,
	input logic [15:0] pm2_5_amb,
	input logic [15:0] pm10_amb,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int fail_count,
	output int due_count,
	output int checked_count,
	output int good_count,
	output int bad_count
);

	// Register copies
	logic [WARMUP_W-1:0] warmup_lim;
	logic [TIMEOUT_W-1:0] timeout_lim;

	// Parser state copy
	logic [4:0] hunt_pos;
	logic [7:0] frame_bytes [32];
	logic [15:0] frame_sum;
	logic started;
	logic [31:0] start_ms;
	logic [31:0] good_ms;
	logic have_good;
	logic held_valid;
	readings_t held;

	result_t due_results [$];
	int n_err, n_checked, n_good, n_bad;

	function automatic logic warm_elapsed(input logic [31:0] t);
		logic [31:0] since;
		since = t - start_ms;
		return started && (since >= {12'd0, warmup_lim});
	endfunction

	function automatic logic silence_exceeded(input logic [31:0] t);
		logic [31:0] since;
		since = t - (have_good ? good_ms : start_ms);
		return since > {10'd0, timeout_lim};
	endfunction

	// One received byte through the frame hunter; returns the frame outcome
	function automatic logic [1:0] absorb_byte(input logic [7:0] b, input logic [31:0] t);
		if (hunt_pos == 5'd0) begin
			if (b == PRE_A) begin
				frame_bytes[0] = b;
				frame_sum = 16'(b);
				hunt_pos = 5'd1;
			end
			return OUT_NONE;
		end
		if (hunt_pos == 5'd1) begin
			if (b == PRE_B) begin
				frame_bytes[1] = b;
				frame_sum = frame_sum + 16'(b);
				hunt_pos = 5'd2;
			end else if (b == PRE_A) begin
				// repeated first preamble byte keeps the hunt armed
				frame_bytes[0] = b;
				frame_sum = 16'(b);
			end else begin
				hunt_pos = 5'd0;
			end
			return OUT_NONE;
		end
		frame_bytes[hunt_pos] = b;
		if (hunt_pos < POS_SUM_END)
			frame_sum = frame_sum + 16'(b);
		if (hunt_pos != POS_LAST) begin
			hunt_pos = hunt_pos + 5'd1;
			return OUT_NONE;
		end
		hunt_pos = 5'd0;
		if (frame_sum != {frame_bytes[POS_SUM_END], b})
			return OUT_BAD;
		for (int i = 0; i < NUM_RD; i++)
			held[i] = {frame_bytes[POS_RD_FIRST + 2 * i], frame_bytes[POS_RD_FIRST + 2 * i + 1]};
		good_ms = t;
		have_good = 1'b1;
		held_valid = warm_elapsed(t);
		return OUT_GOOD;
	endfunction

	// Expected result of one accepted request; updates the state copy
	function automatic result_t parse_request(input logic [1:0] op, input logic [7:0] b,
			input logic [31:0] t);
		result_t r;
		logic [1:0] outcome;
		logic warm;
		outcome = OUT_NONE;
		if (!started) begin
			started = 1'b1;
			start_ms = t;
		end
		if (op == OP_BYTE) begin
			outcome = absorb_byte(b, t);
		end else if (op == OP_RESYNC) begin
			hunt_pos = 5'd0;
			have_good = 1'b0;
			held_valid = 1'b0;
		end
		// spare code 3 falls through as a poll
		if (outcome == OUT_GOOD)
			n_good++;
		if (outcome == OUT_BAD)
			n_bad++;
		warm = warm_elapsed(t);
		r.new_reading = (outcome == OUT_GOOD) && warm;
		r.checksum_error = (outcome == OUT_BAD);
		r.reading_valid = held_valid;
		r.warmed_up = warm;
		r.timed_out = silence_exceeded(t);
		r.readings = held;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			n_err++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_lim = WARMUP_RST;
			timeout_lim = TIMEOUT_RST;
			hunt_pos = 5'd0;
			frame_sum = 16'd0;
			started = 1'b0;
			start_ms = 32'd0;
			good_ms = 32'd0;
			have_good = 1'b0;
			held_valid = 1'b0;
			held = '0;
			due_results.delete();
			n_err = 0;
			n_checked = 0;
			n_good = 0;
			n_bad = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_WARMUP)
					warmup_lim = pwdata[WARMUP_W-1:0];
				else
					timeout_lim = pwdata[TIMEOUT_W-1:0];
			end

			// results against the oldest expectation
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t ns: result with no request outstanding", $time);
					n_err++;
				end else begin
					result_t want;
					want = due_results.pop_front();
					n_checked++;
					check_field("new_reading", 16'(want.new_reading), 16'(new_reading));
					check_field("checksum_error", 16'(want.checksum_error),
						16'(checksum_error));
					check_field("reading_valid", 16'(want.reading_valid), 16'(reading_valid));
					check_field("warmed_up", 16'(want.warmed_up), 16'(warmed_up));
					check_field("timed_out", 16'(want.timed_out), 16'(timed_out));
					check_field("pm1_0_std", want.readings[0], pm1_0_std);
					check_field("pm2_5_std", want.readings[1], pm2_5_std);
					check_field("pm10_std", want.readings[2], pm10_std);
					check_field("pm1_0_amb", want.readings[3], pm1_0_amb);
					check_field("pm2_5_amb", want.readings[4], pm2_5_amb);
					check_field("pm10_amb", want.readings[5], pm10_amb);
				end
			end

			// accepted requests
			if (in_valid && in_ready)
				due_results.push_back(parse_request(operation, rx_byte, now_ms));
		end
		fail_count <= n_err;
		due_count <= due_results.size();
		checked_count <= n_checked;
		good_count <= n_good;
		bad_count <= n_bad;
	end

endmodule

// ===== tb/particulate_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the particulate frame parser: clock, reset, APB setup,
// directed and random request traffic, and the final verdict.
// Depends on pfp_pkg, particulate_frame_parser and pfp_result_checker.
module particulate_frame_parser_tb;
	import pfp_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int PHASE_ITEMS = 240;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] operation;
	logic [7:0] rx_byte;
	logic [31:0] now_ms;
	logic out_valid;
	logic out_ready;
	logic new_reading;
	logic checksum_error;
	logic reading_valid;
	logic warmed_up;
	logic timed_out;
	logic [15:0] pm1_0_std;
	logic [15:0] pm2_5_std;
	logic [15:0] pm10_std;
	logic [15:0] pm1_0_amb;
	logic [15:0] pm2_5_amb;
	logic [15:0] pm10_amb;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	int fail_count, due_count, checked_count, good_count, bad_count;

	logic steady;
	logic [31:0] t_now;
	int unsigned step_max;
	int n_items;
	int n_settings;

	particulate_frame_parser uut (.*);
	pfp_result_checker u_checker (.*);

	always #10 clk = ~clk;

	// Receiver: random stalls unless in a no-idle stretch
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 19);

	// Sensor clock: small random steps, rare jumps anywhere in 32 bits
	function automatic logic [31:0] next_ms();
		if ($urandom_range(0, 59) == 0)
			t_now = $urandom();
		else
			t_now = t_now + $urandom_range(0, step_max);
		return t_now;
	endfunction

	task automatic send_req(input logic [1:0] op, input logic [7:0] b, input logic [31:0] t);
		if (!steady && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		now_ms <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_items++;
	endtask

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Stop sending and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
	endtask

	// One sensor frame: mostly good, some corrupted, some cut by a resync
	task automatic send_frame();
		logic [7:0] fb [32];
		logic [15:0] sum;
		int fill, cut, idx;
		fill = $urandom_range(0, 9);
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 31) : 32;
		fb[0] = PRE_A;
		fb[1] = PRE_B;
		sum = 16'(PRE_A) + 16'(PRE_B);
		for (int i = 2; i < 30; i++) begin
			fb[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
			sum = sum + 16'(fb[i]);
		end
		fb[30] = sum[15:8];
		fb[31] = sum[7:0];
		if ($urandom_range(0, 7) == 0) begin
			idx = $urandom_range(2, 31);
			fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
		end
		// stray lead-in byte, sometimes a repeated first preamble byte
		if ($urandom_range(0, 3) == 0)
			send_req(OP_BYTE, ($urandom_range(0, 1) ? PRE_A : 8'($urandom)), next_ms());
		for (int i = 0; i < 32; i++) begin
			if (i == cut)
				send_req(OP_RESYNC, 8'($urandom), next_ms());
			if ($urandom_range(0, 19) == 0)
				send_req(($urandom_range(0, 1) ? OP_POLL : OP_SPARE), 8'($urandom), next_ms());
			send_req(OP_BYTE, fb[i], next_ms());
		end
	endtask

	// Loose traffic: any operation, bytes biased toward preamble values
	task automatic send_noise();
		logic [1:0] op;
		logic [7:0] b;
		op = $urandom_range(0, 1) ? OP_BYTE : 2'($urandom);
		case ($urandom_range(0, 3))
			0: b = PRE_A;
			1: b = PRE_B;
			default: b = 8'($urandom);
		endcase
		send_req(op, b, next_ms());
	endtask

	task automatic run_phase(input logic [31:0] warm, input logic [31:0] tmo,
			input int unsigned step, input logic calm);
		int first;
		drain();
		steady <= calm;
		reg_write({REG_WARMUP, 2'b00}, warm);
		reg_write({REG_TIMEOUT, 2'b00}, tmo);
		n_settings++;
		step_max = step;
		t_now = 32'd0;
		first = n_items;
		while (n_items - first < PHASE_ITEMS) begin
			if ($urandom_range(0, 9) < 7)
				send_frame();
			else
				send_noise();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_POLL;
		rx_byte <= 8'h00;
		now_ms <= 32'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= 32'd0;
		steady <= 1'b0;
		n_items = 0;
		n_settings = 1;
		step_max = 0;
		t_now = 32'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed start at reset limits (warm-up 30000, timeout 10000)
		send_req(OP_POLL, 8'h00, 32'd0);            // start latched at time zero
		send_req(OP_SPARE, 8'hFF, 32'd5);           // spare code acts as a poll
		send_req(OP_BYTE, 8'hFF, 32'd10);           // junk while hunting
		send_req(OP_BYTE, PRE_A, 32'd20);
		send_req(OP_BYTE, 8'h13, 32'd30);           // broken preamble
		send_req(OP_BYTE, PRE_A, 32'd40);
		send_req(OP_BYTE, PRE_A, 32'd50);           // repeated first byte re-arms
		send_req(OP_BYTE, PRE_B, 32'd60);
		send_req(OP_BYTE, 8'h00, 32'd70);
		send_req(OP_RESYNC, 8'hA5, 32'd80);         // resync inside a frame
		send_req(OP_BYTE, PRE_B, 32'd90);           // second byte alone does not sync
		send_req(OP_POLL, 8'h5A, 32'd10000);        // timeout edge: not yet
		send_req(OP_POLL, 8'h00, 32'd10001);
		send_req(OP_POLL, 8'h00, 32'd29999);        // warm-up edge
		send_req(OP_POLL, 8'h00, 32'd30000);
		send_req(OP_BYTE, PRE_A, 32'hFFFF_FFFF);    // wrapped time difference
		send_req(OP_RESYNC, 8'h00, 32'hFFFF_FFFF);

		// Random traffic under several limit settings
		run_phase(32'd0, 32'd0, 4, 1'b0);
		run_phase(32'h000F_FFFF, 32'h003F_FFFF, 40000, 1'b1);
		run_phase(32'd600000, 32'd3600000, 30000, 1'b0);
		run_phase(32'(WARMUP_RST), 32'(TIMEOUT_RST), 800, 1'b0);
		repeat (3)
			run_phase(($urandom() & 32'hFFF0_0000) | $urandom_range(0, 8000),
				($urandom() & 32'hFFC0_0000) | $urandom_range(0, 8000), 200, 1'b0);

		drain();
		repeat (6) @(posedge clk);
		$display("Sent %0d requests over %0d limit settings: directed edges, framed and loose traffic.",
			n_items, n_settings);
		$display("Checked %0d results, %0d good frames and %0d checksum failures among them.",
			checked_count, good_count, bad_count);
		if (fail_count == 0 && due_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("Timeout: %0d results still outstanding", due_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
